[rtl/srr_pkg.sv]
package srr_pkg;

   localparam int SeqBits  = 8;
   localparam int LenBits  = 10;
   localparam int TsBits   = 32;
   localparam int TagBits  = 6;
   localparam int WinBits  = 5;
   localparam int SlotBits = 5;
   localparam int EndAcks  = 5;

   typedef enum logic [1:0] {
      KIND_DELIVER = 2'd0,
      KIND_ACK     = 2'd1,
      KIND_NACK    = 2'd2
   } kind_type;

   typedef struct packed {
      logic               decode_ok;
      logic               is_data;
      logic               truncated;
      logic [SeqBits-1:0] rx_seqnum;
      logic [LenBits-1:0] rx_length;
      logic [TsBits-1:0]  rx_timestamp;
      logic [TagBits-1:0] buffer_tag;
   } req_type;

   typedef struct packed {
      kind_type           out_kind;
      logic [SeqBits-1:0] out_seqnum;
      logic [WinBits-1:0] out_window;
      logic [TsBits-1:0]  out_timestamp;
      logic [TagBits-1:0] out_buffer_tag;
      logic [LenBits-1:0] out_length;
      logic               last;
      logic               transfer_done;
   } rsp_type;

   typedef struct packed {
      logic [TsBits-1:0]  timestamp;
      logic [LenBits-1:0] length;
      logic [TagBits-1:0] tag;
   } slot_type;

endpackage

[rtl/selective_repeat_receiver_core.sv]
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  srr_pkg::req_type, one decoded packet
// rsp_      out        rsp_valid/rsp_stall  srr_pkg::rsp_type, delivery, ACK or NACK
//
// An accepted packet is registered and then classified in the decide state; a
// packet with one result is answered from there when the output is free. An
// in-order packet releases one stored successor per cycle, while rsp_ is not
// stalled, from the slot memory (one read port, registered read), then one ACK.
// End of transfer sends five ACKs. Stalls on rsp_ hold the sequencer; req_stall
// is high whenever a packet is being worked on.
// Reset is synchronous; no store entry is valid after it.
module selective_repeat_receiver_core #(
   parameter int WINDOW      = 31,
   parameter int MAX_PAYLOAD = 512
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  srr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output srr_pkg::rsp_type rsp_data
);
   import srr_pkg::*;

   localparam logic [WinBits-1:0] WinMax = WinBits'(WINDOW);
   localparam logic [SeqBits-1:0] WinSeq = SeqBits'(WINDOW);
   localparam logic [LenBits-1:0] MaxLen = LenBits'(MAX_PAYLOAD);
   localparam int Slots = 2 ** SlotBits;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_FETCH,
      S_ACK,
      S_END
   } state_type;

   state_type            state_ff, state_in;
   logic [SeqBits-1:0]   expected_ff, expected_in;
   logic [WinBits-1:0]   count_ff, count_in;
   logic [Slots-1:0]     valid_ff, valid_in;
   logic                 finished_ff, finished_in;
   logic [SlotBits:0]    rd_count_ff, rd_count_in;
   logic [2:0]           rep_count_ff, rep_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   req_type              item_ff, item_in;
   logic [TsBits-1:0]    ack_ts_ff, ack_ts_in;

   slot_type             slot_mem [Slots];
   slot_type             rd_data_ff;
   slot_type             wr_data;
   logic                 mem_we, mem_re;
   logic [SlotBits-1:0]  mem_waddr, mem_raddr;

   logic                 out_free;
   logic                 bad, is_end, in_order, in_win;
   logic [SeqBits-1:0]   diff, expected_inc;
   logic [SlotBits-1:0]  next_slot, seq_slot;
   logic [WinBits-1:0]   window_cur;

   function automatic rsp_type make_rsp(kind_type kind, logic [SeqBits-1:0] seq,
                                        logic [WinBits-1:0] win, logic [TsBits-1:0] ts,
                                        logic [TagBits-1:0] tag, logic [LenBits-1:0] len,
                                        logic last, logic done);
      rsp_type r;
      r.out_kind       = kind;
      r.out_seqnum     = seq;
      r.out_window     = win;
      r.out_timestamp  = ts;
      r.out_buffer_tag = tag;
      r.out_length     = len;
      r.last           = last;
      r.transfer_done  = done;
      return r;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign expected_inc = expected_ff + SeqBits'(1);
   assign next_slot    = expected_inc[SlotBits-1:0];
   assign seq_slot     = item_ff.rx_seqnum[SlotBits-1:0];
   assign diff         = item_ff.rx_seqnum - expected_ff;
   assign window_cur   = WinMax - count_ff;

   assign bad      = !item_ff.decode_ok || (item_ff.rx_length > MaxLen);
   assign in_order = (item_ff.rx_seqnum == expected_ff);
   assign is_end   = item_ff.is_data && (item_ff.rx_length == '0) && !item_ff.truncated
                     && in_order;
   assign in_win   = (diff < WinSeq);

   assign wr_data.timestamp = item_ff.rx_timestamp;
   assign wr_data.length    = item_ff.rx_length;
   assign wr_data.tag       = item_ff.buffer_tag;

   always_comb begin
      state_in     = state_ff;
      expected_in  = expected_ff;
      count_in     = count_ff;
      valid_in     = valid_ff;
      finished_in  = finished_ff;
      rd_count_in  = rd_count_ff;
      rep_count_in = rep_count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      item_in      = item_ff;
      ack_ts_in    = ack_ts_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_waddr    = seq_slot;
      mem_raddr    = next_slot;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (finished_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               state_in = S_IDLE;
               priority if (bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = make_rsp(KIND_NACK, expected_ff, window_cur,
                                          item_ff.rx_timestamp, '0, '0, 1'b1, 1'b0);
               end else if (is_end) begin
                  expected_in  = expected_inc;
                  finished_in  = 1'b1;
                  rep_count_in = '0;
                  state_in     = S_END;
               end else if (item_ff.truncated) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = make_rsp(KIND_NACK, item_ff.rx_seqnum, window_cur,
                                          item_ff.rx_timestamp, '0, '0, 1'b1, 1'b0);
               end else if (in_order) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = make_rsp(KIND_DELIVER, item_ff.rx_seqnum, '0,
                                          item_ff.rx_timestamp, item_ff.buffer_tag,
                                          item_ff.rx_length, 1'b0, 1'b0);
                  expected_in  = expected_inc;
                  ack_ts_in    = item_ff.rx_timestamp;
                  rd_count_in  = '0;
                  if (valid_ff[next_slot]) begin
                     mem_re              = 1'b1;
                     valid_in[next_slot] = 1'b0;
                     count_in            = (count_ff != '0) ? count_ff - WinBits'(1) : count_ff;
                     rd_count_in         = (SlotBits+1)'(1);
                     state_in            = S_FETCH;
                  end else begin
                     state_in = S_ACK;
                  end
               end else if (in_win) begin
                  // A repeat of a packet already held produces nothing.
                  if (!valid_ff[seq_slot]) begin
                     mem_we             = 1'b1;
                     valid_in[seq_slot] = 1'b1;
                     count_in           = count_ff + WinBits'(1);
                     rsp_valid_in       = 1'b1;
                     rsp_data_in        = make_rsp(KIND_ACK, expected_ff,
                                                   WinMax - (count_ff + WinBits'(1)),
                                                   item_ff.rx_timestamp, '0, '0, 1'b1, 1'b0);
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = make_rsp(KIND_ACK, expected_ff, window_cur,
                                          item_ff.rx_timestamp, '0, '0, 1'b1, 1'b0);
               end
            end
         end
         S_FETCH: begin
            // The read data register holds until the next read is issued, so a
            // stall here simply waits.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(KIND_DELIVER, expected_ff, '0, rd_data_ff.timestamp,
                                       rd_data_ff.tag, rd_data_ff.length, 1'b0, 1'b0);
               ack_ts_in    = rd_data_ff.timestamp;
               expected_in  = expected_inc;
               if (!rd_count_ff[SlotBits] && valid_ff[next_slot]) begin
                  mem_re              = 1'b1;
                  valid_in[next_slot] = 1'b0;
                  count_in            = (count_ff != '0) ? count_ff - WinBits'(1) : count_ff;
                  rd_count_in         = rd_count_ff + (SlotBits+1)'(1);
               end else begin
                  state_in = S_ACK;
               end
            end
         end
         S_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(KIND_ACK, expected_ff, window_cur, ack_ts_ff,
                                       '0, '0, 1'b1, 1'b0);
               state_in     = S_IDLE;
            end
         end
         S_END: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = make_rsp(KIND_ACK, expected_ff, window_cur,
                                       item_ff.rx_timestamp, '0, '0,
                                       rep_count_ff == 3'(EndAcks - 1), 1'b1);
               rep_count_in = rep_count_ff + 3'd1;
               if (rep_count_ff == 3'(EndAcks - 1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         expected_ff  <= '0;
         count_ff     <= '0;
         valid_ff     <= '0;
         finished_ff  <= 1'b0;
         rd_count_ff  <= '0;
         rep_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         expected_ff  <= expected_in;
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         finished_ff  <= finished_in;
         rd_count_ff  <= rd_count_in;
         rep_count_ff <= rep_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      item_ff     <= item_in;
      ack_ts_ff   <= ack_ts_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= slot_mem[mem_raddr];
      end
   end

   // The store never holds more than the window allows.
   assert property (@(posedge clock) disable iff (reset)
      count_ff < WinMax)
      else $error("stored count reached the window size");

   // The stored count tracks the valid bits exactly.
   assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(count_ff))
      else $error("stored count and valid bits disagree");

   // End-of-transfer acknowledgements only come after the transfer is closed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.transfer_done |-> finished_ff)
      else $error("transfer_done shown before the transfer finished");

endmodule
